FILE: design/sws_pkg.sv
package sws_pkg;

  // Field widths fixed by the interface
  localparam int ELEM_W  = 16;
  localparam int SUM_W   = 24;
  localparam int CFG_W   = 5;

  // Window side after reset
  localparam logic [CFG_W-1:0] CFG_WINDOW_RESET = CFG_W'(3);

  typedef logic signed [ELEM_W-1:0] elem_t;
  typedef logic signed [SUM_W-1:0]  win_sum_t;
  typedef logic [CFG_W-1:0]         cfg_win_t;

endpackage

FILE: design/square_window_sum_strips.sv
// Streaming k by k box sum over an N by N matrix (N = MATRIX_SIZE).
// Input channel (in_valid, in_stall, in_element_value): one signed element
// per transaction, matrix delivered row by row in raster order. After the
// last element of a matrix the next element starts a new one.
// Result channel (out_valid, out_stall, out_window_sum, out_row_last,
// out_matrix_last): one transaction for each element that completes the
// bottom-right corner of a k by k square; other elements give none.
// Configuration: cfg_wr_en writes cfg_window_size (k, 0 acts as 1, values
// above MAX_WINDOW act as MAX_WINDOW) and restarts the matrix at row 0,
// column 0. Write only while no transaction is in flight.
// Throughput: one element per cycle while the result channel does not stall,
// set by the single read-modify-write of the column strip memory and one row
// history read per element. Memories are read on the accepting edge into
// stage one, then the sum adds into the output register.
// Reset (synchronous, rst_n low) empties the pipeline, sets k to 3 and the
// position to row 0, column 0. The memories need no clearing pass.
// While out_stall holds a result, elements without a result keep flowing;
// the next element with a result waits in the compute stage and stalls the
// input until the waiting result leaves.
module square_window_sum_strips
  import sws_pkg::*;
#(
  parameter int MATRIX_SIZE = 64,
  parameter int MAX_WINDOW  = 16
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     cfg_wr_en,
  input  cfg_win_t cfg_window_size,
  input  logic     in_valid,
  output logic     in_stall,
  input  elem_t    in_element_value,
  output logic     out_valid,
  input  logic     out_stall,
  output win_sum_t out_window_sum,
  output logic     out_row_last,
  output logic     out_matrix_last
);

  localparam int CW    = (MATRIX_SIZE > 1) ? $clog2(MATRIX_SIZE) : 1;
  localparam int SW    = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int KW    = $clog2(MAX_WINDOW + 1);
  localparam int STRIP_W = ELEM_W + ((MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 0);

  typedef logic signed [STRIP_W-1:0] strip_t;

  // Memories
  elem_t  hist_mem [MAX_WINDOW][MATRIX_SIZE];
  strip_t strip_mem [MATRIX_SIZE];

  // Control registers
  cfg_win_t       win_r;
  logic [CW-1:0]  row_r, row_nxt;
  logic [CW-1:0]  col_r, col_nxt;
  logic [SW-1:0]  slot_r, slot_nxt;
  win_sum_t       hsum_r, hsum_nxt;

  // Stage one (data read from memory)
  logic           s1_valid_r;
  elem_t          s1_x_r;
  logic [CW-1:0]  s1_col_r;
  logic           s1_row0_r, s1_sub_r, s1_hs_en_r, s1_col0_r, s1_csub_r;
  logic           s1_prod_r, s1_rl_r, s1_ml_r;
  elem_t          rd_hist_r;
  strip_t         rd_strip_r;
  logic           fwd_r;
  strip_t         fwd_val_r;

  // Strip sums of the current row, newest first
  strip_t         tap_r [MAX_WINDOW];

  // Output register
  logic           out_valid_r;
  win_sum_t       out_sum_r;
  logic           out_rl_r, out_ml_r;

  logic [KW-1:0]  k_eff;
  logic [KW-1:0]  k_m1;
  logic [SW-1:0]  old_slot;
  int             slot_diff;
  logic           accept, s1_adv, out_free;
  logic           st_row0, st_sub, st_hs_en, st_col0, st_csub, st_prod, st_rl, st_ml;
  logic           last_col, last_row;
  strip_t         strip_in, strip_new;
  win_sum_t       tap_sel;

  // Effective window side
  always_comb begin
    if (win_r == '0) begin
      k_eff = KW'(1);
    end else if (int'(win_r) > MAX_WINDOW) begin
      k_eff = KW'(MAX_WINDOW);
    end else begin
      k_eff = KW'(win_r);
    end
    k_m1 = k_eff - KW'(1);
  end

  // Handshake
  assign out_free = !out_valid_r || !out_stall;
  assign s1_adv   = s1_valid_r && (!s1_prod_r || out_free);
  assign in_stall = s1_valid_r && !s1_adv;
  assign accept   = in_valid && !in_stall;

  // Decode the position of the incoming element
  always_comb begin
    last_col = (int'(col_r) == MATRIX_SIZE - 1);
    last_row = (int'(row_r) == MATRIX_SIZE - 1);
    st_row0  = (row_r == '0);
    st_sub   = (int'(row_r) >= int'(k_eff));
    st_hs_en = (int'(k_eff) <= MATRIX_SIZE) && (int'(row_r) + 1 >= int'(k_eff));
    st_col0  = (col_r == '0);
    st_csub  = (int'(col_r) >= int'(k_eff));
    st_prod  = st_hs_en && (int'(col_r) + 1 >= int'(k_eff));
    st_rl    = last_col;
    st_ml    = last_col && last_row;
    slot_diff = int'(slot_r) - int'(k_eff);
    if (slot_diff < 0) begin
      slot_diff = slot_diff + MAX_WINDOW;
    end
    old_slot = SW'(slot_diff);
  end

  // Advance the raster position
  always_comb begin
    row_nxt  = row_r;
    col_nxt  = col_r + CW'(1);
    slot_nxt = slot_r;
    if (last_col) begin
      col_nxt = '0;
      if (last_row) begin
        row_nxt  = '0;
        slot_nxt = '0;
      end else begin
        row_nxt  = row_r + CW'(1);
        slot_nxt = (int'(slot_r) == MAX_WINDOW - 1) ? '0 : slot_r + SW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r  <= CFG_WINDOW_RESET;
      row_r  <= '0;
      col_r  <= '0;
      slot_r <= '0;
    end else if (cfg_wr_en) begin
      win_r  <= cfg_window_size;
      row_r  <= '0;
      col_r  <= '0;
      slot_r <= '0;
    end else if (accept) begin
      row_r  <= row_nxt;
      col_r  <= col_nxt;
      slot_r <= slot_nxt;
    end
  end

  // Row history: read the element k rows up, write the new one (read first)
  always_ff @(posedge clk) begin
    if (accept) begin
      rd_hist_r                 <= hist_mem[old_slot][col_r];
      hist_mem[slot_r][col_r]   <= in_element_value;
    end
  end

  // Column strip memory: read on accept, write back from stage one
  always_ff @(posedge clk) begin
    if (accept) begin
      rd_strip_r <= strip_mem[col_r];
    end
    if (s1_adv) begin
      strip_mem[s1_col_r] <= strip_new;
    end
  end

  // Capture a write-back to the column being read in the same cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_r <= 1'b0;
    end else if (accept) begin
      fwd_r <= s1_adv && (s1_col_r == col_r);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      fwd_val_r <= strip_new;
    end
  end

  // Stage one control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (accept) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_x_r     <= in_element_value;
      s1_col_r   <= col_r;
      s1_row0_r  <= st_row0;
      s1_sub_r   <= st_sub;
      s1_hs_en_r <= st_hs_en;
      s1_col0_r  <= st_col0;
      s1_csub_r  <= st_csub;
      s1_prod_r  <= st_prod;
      s1_rl_r    <= st_rl;
      s1_ml_r    <= st_ml;
    end
  end

  // Strip update and horizontal sum
  always_comb begin
    strip_in = fwd_r ? fwd_val_r : rd_strip_r;
    if (s1_row0_r) begin
      strip_new = STRIP_W'(s1_x_r);
    end else if (s1_sub_r) begin
      strip_new = strip_in + STRIP_W'(s1_x_r) - STRIP_W'(rd_hist_r);
    end else begin
      strip_new = strip_in + STRIP_W'(s1_x_r);
    end
    tap_sel  = SUM_W'(tap_r[k_m1[SW-1:0]]);
    hsum_nxt = s1_col0_r ? SUM_W'(strip_new) : hsum_r + SUM_W'(strip_new);
    if (s1_csub_r) begin
      hsum_nxt = hsum_nxt - tap_sel;
    end
  end

  // Shift the strip line by one column
  always_ff @(posedge clk) begin
    if (s1_adv) begin
      tap_r[0] <= strip_new;
      for (int i = 1; i < MAX_WINDOW; i++) begin
        tap_r[i] <= tap_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hsum_r <= '0;
    end else if (cfg_wr_en) begin
      hsum_r <= '0;
    end else if (s1_adv && s1_hs_en_r) begin
      hsum_r <= hsum_nxt;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv && s1_prod_r) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_prod_r) begin
      out_sum_r <= hsum_nxt;
      out_rl_r  <= s1_rl_r;
      out_ml_r  <= s1_ml_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_window_sum  = out_sum_r;
  assign out_row_last    = out_rl_r;
  assign out_matrix_last = out_ml_r;

  // An empty compute stage never holds off the input
  assert property (@(posedge clk) disable iff (!rst_n) !s1_valid_r |-> !in_stall)
    else $error("input stalled with empty compute stage");

  // A result that still waits is never overwritten
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |=> ($stable(out_sum_r) && out_valid_r))
    else $error("waiting result overwritten");

  // Back-to-back access to one strip entry only arises with a single column
  assert property (@(posedge clk) disable iff (!rst_n) fwd_r |-> (MATRIX_SIZE == 1))
    else $error("unexpected strip forwarding");

  // The matrix ends only at the end of a row
  assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && s1_ml_r) |-> s1_rl_r)
    else $error("matrix end flagged mid-row");

endmodule
